// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the flash command interface RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fci_pkg.sv =====
// ----------------------------------------------------------------------------
// fci_pkg
// Types and constants shared by the flash command interface.
// ----------------------------------------------------------------------------
`default_nettype none

package fci_pkg;

    localparam int unsigned ARRAY_ADDR_BITS = 20;
    localparam int unsigned PAGE_ADDR_BITS  = 16;
    localparam int unsigned BUS_ADDR_BITS   = 24;

    localparam int unsigned SIZE_CODE_RAW =
        (ARRAY_ADDR_BITS - 10 > 12) ? 12 : (ARRAY_ADDR_BITS - 10);

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [7:0] CMD_RESET_ZERO  = 8'h00;
    localparam logic [7:0] CMD_RESET_ONES  = 8'hFF;
    localparam logic [7:0] CMD_PROGRAM_A   = 8'h10;
    localparam logic [7:0] CMD_PROGRAM_B   = 8'h40;
    localparam logic [7:0] CMD_STATUS      = 8'h70;
    localparam logic [7:0] CMD_EXT_STATUS  = 8'h71;
    localparam logic [7:0] CMD_VENDOR_VIEW = 8'h75;

    localparam logic [15:0] HIST_PAGE_ERASE = 16'h20D0;
    localparam logic [15:0] HIST_CHIP_ERASE = 16'hA7D0;

    localparam logic [15:0] EXT_STATUS_OFF_A = 16'h0002;
    localparam logic [15:0] EXT_STATUS_OFF_B = 16'h0004;
    localparam logic [7:0]  EXT_STATUS_A     = 8'hC0;
    localparam logic [7:0]  EXT_STATUS_B     = 8'h82;
    localparam logic [7:0]  COMPAT_STATUS    = 8'h80;

    localparam logic [6:0] VENDOR_WIN_PAGE = 7'h7F;
    localparam logic [7:0] VENDOR_WIN_LAST = 8'h13;
    localparam logic [7:0] VENDOR_OFF_MAKER = 8'h00;
    localparam logic [7:0] VENDOR_OFF_TYPE  = 8'h02;
    localparam logic [7:0] VENDOR_OFF_SIZE  = 8'h06;
    localparam logic [7:0] VENDOR_MAKER     = 8'h4D;
    localparam logic [7:0] VENDOR_TYPE      = 8'h50;
    localparam logic [7:0] VENDOR_SIZE      = 8'h10 | 8'(SIZE_CODE_RAW);

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [ARRAY_ADDR_BITS-1:0] PAGE_MASK =
        ARRAY_ADDR_BITS'((64'd1 << PAGE_ADDR_BITS) - 64'd1);
    localparam logic [ARRAY_ADDR_BITS-1:0] FULL_MASK = '1;

    typedef struct packed {
        logic                     opcode;
        logic [BUS_ADDR_BITS-1:0] address;
        logic [7:0]               write_data;
        logic                     debug_access;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       write_enabled;
    } rsp_t;

endpackage

`default_nettype wire

// ===== sv/flash_command_interface.sv =====
// ----------------------------------------------------------------------------
// flash_command_interface
// Command user interface over a byte-wide flash array held in on-chip RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one request can be
// taken every cycle while busy is low. Its result is on result, marked by
// done for exactly one cycle, once the request has passed through the
// registers s2_valid_reg and done_reg; there is no way to hold it off. The
// array has one write port, which sets the erase times: after reset busy
// stays high while the whole array is cleared to 0xFF. A page erase keeps
// busy high while the command is decoded and then while each byte of its
// page is written (the whole array if it is not larger than a page), and a
// chip erase likewise while the command is decoded and then while each byte
// of the whole array is written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module flash_command_interface
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire fci_pkg::req_t request,
    output logic               done,
    output fci_pkg::rsp_t      result
);
    import fci_pkg::*;

    typedef logic [ARRAY_ADDR_BITS-1:0] idx_t;

    logic [7:0] flash_mem [2**ARRAY_ADDR_BITS];

    logic       accept;
    logic [7:0] mem_rdata_reg;
    logic       fwd_hit_reg;
    logic [7:0] fwd_data_reg;
    logic [7:0] mem_rdata;

    logic       mem_we;
    idx_t       mem_widx;
    logic [7:0] mem_wdata;
    idx_t       rd_idx;

    logic       s2_valid_reg;
    req_t       s2_req_reg;
    idx_t       s2_idx;

    logic [15:0] hist_reg, hist_next;
    logic        status_reg, status_next;
    logic        ext_reg, ext_next;
    logic        vendor_reg, vendor_next;
    logic        armed_reg, armed_next;

    logic        prog_we;
    logic        erase_page;
    logic        erase_chip;
    logic [7:0]  rd_byte;

    logic        sweep_active_reg;
    idx_t        sweep_cnt_reg;
    idx_t        sweep_base_reg;
    idx_t        sweep_limit_reg;

    logic        done_reg;
    rsp_t        result_reg;

    assign accept = start && !busy;
    assign busy   = sweep_active_reg || erase_page || erase_chip;
    assign rd_idx = request.address[ARRAY_ADDR_BITS-1:0];
    assign s2_idx = s2_req_reg.address[ARRAY_ADDR_BITS-1:0];

    assign mem_rdata = fwd_hit_reg ? fwd_data_reg : mem_rdata_reg;

    // array port: sweep writes have priority; never overlap with a program
    assign mem_we    = sweep_active_reg || prog_we;
    assign mem_widx  = sweep_active_reg ? (sweep_base_reg | sweep_cnt_reg) : s2_idx;
    assign mem_wdata = sweep_active_reg ? ERASED_BYTE
                                        : (mem_rdata & s2_req_reg.write_data);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            flash_mem[mem_widx] <= mem_wdata;
        end
        if (accept)
        begin
            mem_rdata_reg <= flash_mem[rd_idx];
        end
    end

    always_comb
    begin
        hist_next   = hist_reg;
        status_next = status_reg;
        ext_next    = ext_reg;
        vendor_next = vendor_reg;
        armed_next  = armed_reg;
        prog_we     = 1'b0;
        erase_page  = 1'b0;
        erase_chip  = 1'b0;
        rd_byte     = 8'h00;
        if (s2_valid_reg)
        begin
            if (s2_req_reg.opcode == OP_READ)
            begin
                priority if (ext_reg && s2_req_reg.address[15:0] == EXT_STATUS_OFF_A)
                begin
                    rd_byte = EXT_STATUS_A;
                end
                else if (ext_reg && s2_req_reg.address[15:0] == EXT_STATUS_OFF_B)
                begin
                    rd_byte = EXT_STATUS_B;
                end
                else if (status_reg)
                begin
                    rd_byte = COMPAT_STATUS;
                    if (!s2_req_reg.debug_access)
                    begin
                        status_next = 1'b0;
                    end
                end
                else if (vendor_reg && s2_req_reg.address[14:8] == VENDOR_WIN_PAGE
                         && s2_req_reg.address[7:0] <= VENDOR_WIN_LAST)
                begin
                    unique case (s2_req_reg.address[7:0])
                        VENDOR_OFF_MAKER: rd_byte = VENDOR_MAKER;
                        VENDOR_OFF_TYPE:  rd_byte = VENDOR_TYPE;
                        VENDOR_OFF_SIZE:  rd_byte = VENDOR_SIZE;
                        default:          rd_byte = 8'h00;
                    endcase
                end
                else
                begin
                    rd_byte = mem_rdata;
                end
            end
            else if (armed_reg)
            begin
                armed_next = 1'b0;
                prog_we    = 1'b1;
            end
            else
            begin
                hist_next = {hist_reg[7:0], s2_req_reg.write_data};
                unique case (s2_req_reg.write_data)
                    CMD_RESET_ZERO, CMD_RESET_ONES:
                    begin
                        status_next = 1'b0;
                        ext_next    = 1'b0;
                        vendor_next = 1'b0;
                    end
                    CMD_PROGRAM_A, CMD_PROGRAM_B: armed_next  = 1'b1;
                    CMD_STATUS:                   status_next = 1'b1;
                    CMD_EXT_STATUS:               ext_next    = 1'b1;
                    CMD_VENDOR_VIEW:              vendor_next = 1'b1;
                    default:
                    begin
                    end
                endcase
                priority if (hist_next == HIST_PAGE_ERASE)
                begin
                    erase_page = 1'b1;
                end
                else if (hist_next == HIST_CHIP_ERASE)
                begin
                    erase_chip = 1'b1;
                end
                else
                begin
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg     <= 1'b0;
            fwd_hit_reg      <= 1'b0;
            hist_reg         <= '0;
            status_reg       <= 1'b0;
            ext_reg          <= 1'b0;
            vendor_reg       <= 1'b0;
            armed_reg        <= 1'b0;
            sweep_active_reg <= 1'b1;
            sweep_cnt_reg    <= '0;
            sweep_base_reg   <= '0;
            sweep_limit_reg  <= FULL_MASK;
            done_reg         <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= accept;
            fwd_hit_reg  <= accept && mem_we && (mem_widx == rd_idx);
            hist_reg     <= hist_next;
            status_reg   <= status_next;
            ext_reg      <= ext_next;
            vendor_reg   <= vendor_next;
            armed_reg    <= armed_next;
            done_reg     <= s2_valid_reg;
            if (sweep_active_reg)
            begin
                if (sweep_cnt_reg == sweep_limit_reg)
                begin
                    sweep_active_reg <= 1'b0;
                end
                else
                begin
                    sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
                end
            end
            else if (erase_page)
            begin
                sweep_active_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
                sweep_base_reg   <= s2_idx & ~PAGE_MASK;
                sweep_limit_reg  <= PAGE_MASK;
            end
            else if (erase_chip)
            begin
                sweep_active_reg <= 1'b1;
                sweep_cnt_reg    <= '0;
                sweep_base_reg   <= '0;
                sweep_limit_reg  <= FULL_MASK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= mem_wdata;
        if (accept)
        begin
            s2_req_reg <= request;
        end
        result_reg.read_data     <= rd_byte;
        result_reg.write_enabled <= armed_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `ASSERT_NEXT(a_erase_starts_sweep, erase_page || erase_chip, sweep_active_reg, "no sweep")
    `ASSERT_IMPL(a_fwd_only_with_item, fwd_hit_reg, s2_valid_reg, "forward hit without item")
    `ASSERT_IMPL(a_no_program_in_sweep, prog_we, !sweep_active_reg, "program write during sweep")

endmodule

`default_nettype wire
